@@ rtl/core/qrs_pkg.sv @@
`default_nettype none
package qrs_pkg;
	localparam int W = 32;
	localparam int F = 16;
	localparam int TW = 16;
	localparam int DW = 2 * W + 2;
	localparam int SW = W + 1;
	localparam int NW = W + 2;
	localparam int MW = W + 1;
	localparam int QW = NW + F;
	localparam int QD = 4;
	localparam int QAW = 2;

	typedef enum logic [1:0] {KIND_NONE, KIND_INF, KIND_LIN, KIND_QUAD} kind_t;

	localparam logic [1:0] OUT_NONE = 2'd0;
	localparam logic [1:0] OUT_ONE = 2'd1;
	localparam logic [1:0] OUT_TWO = 2'd2;
	localparam logic [1:0] OUT_INF = 2'd3;

	typedef struct packed {
		kind_t kind;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] c;
	} job_t;

	typedef struct packed {
		job_t job;
		logic [DW-1:0] disc;
	} entry_t;

	function automatic logic [W-1:0] mag_w(logic [W-1:0] v);
		return v[W-1] ? ((~v) + {{(W-1){1'b0}}, 1'b1}) : v;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/quadratic_root_solver_core.sv @@
`default_nettype none
// Channel   Dir  Contents
// s_axis    in   tdata: coef_a, coef_b, coef_c
// m_axis    out  tdata: root_one, root_two; tuser: outcome, saturated
// cfg       in   tolerance write (cfg_wr_en, cfg_wr_data)
//
// One coefficient triple per cycle while s_axis_tready is high.
// The back pipeline is built from the 33-stage square root and the 50-stage divider pair.
// Reset clears all valid flags, the queue and sets tolerance to 1.
// A stall on m_axis freezes the back pipeline; the four-entry queue lets
// the front keep taking transactions until it fills.
module quadratic_root_solver_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [3*qrs_pkg::W-1:0] s_axis_tdata, // coef_a, coef_b, coef_c
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [2*qrs_pkg::W-1:0] m_axis_tdata, // root_one, root_two
	output logic [2:0] m_axis_tuser, // outcome, saturated
	input wire logic cfg_wr_en,
	input wire logic [qrs_pkg::TW-1:0] cfg_wr_data
);
	localparam int W = qrs_pkg::W;

	logic [qrs_pkg::TW-1:0] tol_q;
	logic push, full, pop, empty, sat;
	qrs_pkg::entry_t push_data, pop_data;
	logic [1:0] outcome;
	logic [W-1:0] r1, r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= {{(qrs_pkg::TW-1){1'b0}}, 1'b1};
		else if (cfg_wr_en) tol_q <= cfg_wr_data;
	end

	qrs_front u_front (
		.clk(clk), .arst_n(arst_n), .tol(tol_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.coef_a(s_axis_tdata[W-1:0]),
		.coef_b(s_axis_tdata[2*W-1:W]),
		.coef_c(s_axis_tdata[3*W-1:2*W]),
		.q_full(full), .push(push), .push_data(push_data)
	);

	qrs_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .empty(empty)
	);

	qrs_back u_back (
		.clk(clk), .arst_n(arst_n), .tol(tol_q),
		.q_empty(empty), .pop(pop), .pop_data(pop_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.outcome(outcome), .root_one(r1), .root_two(r2), .saturated(sat)
	);

	assign m_axis_tdata = {r2, r1};
	assign m_axis_tuser = {sat, outcome};
endmodule
`default_nettype wire

@@ rtl/core/qrs_front.sv @@
`default_nettype none
module qrs_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [qrs_pkg::TW-1:0] tol,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [qrs_pkg::W-1:0] coef_a,
	input wire logic [qrs_pkg::W-1:0] coef_b,
	input wire logic [qrs_pkg::W-1:0] coef_c,
	input wire logic q_full,
	output logic push,
	output qrs_pkg::entry_t push_data
);
	logic v_s1, v_s2, en_s1, en_s2;
	logic [qrs_pkg::W-1:0] a_s1, b_s1, c_s1;
	logic [2*qrs_pkg::W-1:0] bb_s1, ac_s1;
	qrs_pkg::entry_t e_s2, e_nx;
	logic [qrs_pkg::W-1:0] ma, mb, mc, tolx;
	logic [qrs_pkg::DW-1:0] bbx, ac4;
	logic ac_neg, b_near, c_near;

	assign en_s2 = ~v_s2 | ~q_full;
	assign en_s1 = ~v_s1 | en_s2;
	assign in_ready = en_s1;
	assign push = v_s2 & ~q_full;
	assign push_data = e_s2;

	assign ma = qrs_pkg::mag_w(coef_a);
	assign mb = qrs_pkg::mag_w(coef_b);
	assign mc = qrs_pkg::mag_w(coef_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1 <= coef_a;
			b_s1 <= coef_b;
			c_s1 <= coef_c;
			bb_s1 <= {{qrs_pkg::W{1'b0}}, mb} * {{qrs_pkg::W{1'b0}}, mb};
			ac_s1 <= {{qrs_pkg::W{1'b0}}, ma} * {{qrs_pkg::W{1'b0}}, mc};
		end
		if (en_s2) e_s2 <= e_nx;
	end

	always_comb begin
		tolx = {{(qrs_pkg::W-qrs_pkg::TW){1'b0}}, tol};
		bbx = {2'b00, bb_s1};
		ac4 = {ac_s1, 2'b00};
		ac_neg = a_s1[qrs_pkg::W-1] ^ c_s1[qrs_pkg::W-1];
		b_near = (b_s1 == '0) || (qrs_pkg::mag_w(b_s1) < tolx);
		c_near = (c_s1 == '0) || (qrs_pkg::mag_w(c_s1) < tolx);
		e_nx.job.a = a_s1;
		e_nx.job.b = b_s1;
		e_nx.job.c = c_s1;
		e_nx.disc = ac_neg ? (bbx + ac4) : (bbx - ac4);
		if (a_s1 == '0) begin
			if (b_near) e_nx.job.kind = c_near ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
			else e_nx.job.kind = qrs_pkg::KIND_LIN;
		end else if (!ac_neg && (c_s1 != '0) && (ac4 > bbx)) begin
			e_nx.job.kind = qrs_pkg::KIND_NONE;
		end else begin
			e_nx.job.kind = qrs_pkg::KIND_QUAD;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/qrs_fifo.sv @@
`default_nettype none
module qrs_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire qrs_pkg::entry_t push_data,
	output logic full,
	input wire logic pop,
	output qrs_pkg::entry_t pop_data,
	output logic empty
);
	qrs_pkg::entry_t mem_q [qrs_pkg::QD];
	logic [qrs_pkg::QAW-1:0] wp_q, rp_q;
	logic [qrs_pkg::QAW:0] cnt_q;
	logic do_pop;

	assign full = cnt_q == (qrs_pkg::QAW+1)'(qrs_pkg::QD);
	assign empty = cnt_q == '0;
	assign do_pop = pop & ~empty;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (do_pop) rp_q <= rp_q + 1'b1;
			if (push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
endmodule
`default_nettype wire

@@ rtl/core/qrs_sqrt.sv @@
`default_nettype none
module qrs_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire qrs_pkg::entry_t in_data,
	output logic out_valid,
	output qrs_pkg::job_t out_job,
	output logic [qrs_pkg::SW-1:0] out_root,
	output logic [qrs_pkg::SW+1:0] out_rem
);
	localparam int N = qrs_pkg::SW;

	logic v_s [N];
	qrs_pkg::job_t job_s [N];
	logic [qrs_pkg::DW-1:0] d_s [N];
	logic [N-1:0] root_s [N];
	logic [N+1:0] rem_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic vin;
		qrs_pkg::job_t jin;
		logic [qrs_pkg::DW-1:0] din;
		logic [N-1:0] rtin;
		logic [N+1:0] rin, trial;
		logic [N+3:0] sh, diff;
		logic ge;

		if (k == 0) begin : g_first
			assign vin = in_valid;
			assign jin = in_data.job;
			assign din = in_data.disc;
			assign rtin = '0;
			assign rin = '0;
		end else begin : g_next
			assign vin = v_s[k-1];
			assign jin = job_s[k-1];
			assign din = d_s[k-1];
			assign rtin = root_s[k-1];
			assign rin = rem_s[k-1];
		end

		assign sh = {rin, din[qrs_pkg::DW-1-2*k -: 2]};
		assign trial = {rtin, 2'b01};
		assign diff = sh - {2'b00, trial};
		assign ge = sh >= {2'b00, trial};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				job_s[k] <= jin;
				d_s[k] <= din;
				root_s[k] <= {rtin[N-2:0], ge};
				rem_s[k] <= ge ? diff[N+1:0] : sh[N+1:0];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_job = job_s[N-1];
	assign out_root = root_s[N-1];
	assign out_rem = rem_s[N-1];
endmodule
`default_nettype wire

@@ rtl/core/qrs_div.sv @@
`default_nettype none
module qrs_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire qrs_pkg::job_t in_job,
	input wire logic [1:0] in_neg,
	input wire logic [qrs_pkg::NW-1:0] in_num [2],
	input wire logic [qrs_pkg::MW-1:0] in_den,
	output logic out_valid,
	output qrs_pkg::job_t out_job,
	output logic [qrs_pkg::W-1:0] out_quo [2],
	output logic [1:0] out_sat
);
	localparam int N = qrs_pkg::QW;
	localparam int M = qrs_pkg::MW;

	logic v_s [N];
	qrs_pkg::job_t job_s [N];
	logic [M-1:0] dm_s [N];
	logic [1:0] neg_s [N];
	logic [qrs_pkg::NW-1:0] num_s [N][2];
	logic [M-1:0] rem_s [N][2];
	logic [N-1:0] quo_s [N][2];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic vin;
		qrs_pkg::job_t jin;
		logic [M-1:0] dmin;
		logic [1:0] negin;
		logic [qrs_pkg::NW-1:0] nin [2];
		logic [M-1:0] rin [2];
		logic [N-1:0] qin [2];

		if (k == 0) begin : g_first
			assign vin = in_valid;
			assign jin = in_job;
			assign dmin = in_den;
			assign negin = in_neg;
			for (genvar l = 0; l < 2; l++) begin : g_l
				assign nin[l] = in_num[l];
				assign rin[l] = '0;
				assign qin[l] = '0;
			end
		end else begin : g_next
			assign vin = v_s[k-1];
			assign jin = job_s[k-1];
			assign dmin = dm_s[k-1];
			assign negin = neg_s[k-1];
			for (genvar l = 0; l < 2; l++) begin : g_l
				assign nin[l] = num_s[k-1][l];
				assign rin[l] = rem_s[k-1][l];
				assign qin[l] = quo_s[k-1][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				job_s[k] <= jin;
				dm_s[k] <= dmin;
				neg_s[k] <= negin;
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic nbit, ge;
			logic [M:0] sh, diff;

			if (N - 1 - k >= qrs_pkg::F) begin : g_bit
				assign nbit = nin[l][N-1-k-qrs_pkg::F];
			end else begin : g_zero
				assign nbit = 1'b0;
			end

			assign sh = {rin[l], nbit};
			assign diff = sh - {1'b0, dmin};
			assign ge = sh >= {1'b0, dmin};

			always_ff @(posedge clk) begin
				if (en) begin
					num_s[k][l] <= nin[l];
					rem_s[k][l] <= ge ? diff[M-1:0] : sh[M-1:0];
					quo_s[k][l] <= {qin[l][N-2:0], ge};
				end
			end
		end
	end

	logic v_fin_s;
	qrs_pkg::job_t job_fin_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_fin_s <= 1'b0;
		else if (en) v_fin_s <= v_s[N-1];
	end

	always_ff @(posedge clk) begin
		if (en) job_fin_s <= job_s[N-1];
	end

	for (genvar l = 0; l < 2; l++) begin : g_fin
		logic [N:0] qr, limit;
		logic [qrs_pkg::W-1:0] qc, res;
		logic over, ng, up;

		assign ng = neg_s[N-1][l];
		assign up = {rem_s[N-1][l], 1'b0} >= {1'b0, dm_s[N-1]};
		assign qr = {1'b0, quo_s[N-1][l]} + {{N{1'b0}}, up};
		assign limit = ng ? ((N+1)'(1) << (qrs_pkg::W-1))
			: (((N+1)'(1) << (qrs_pkg::W-1)) - (N+1)'(1));
		assign over = qr > limit;
		assign qc = over ? limit[qrs_pkg::W-1:0] : qr[qrs_pkg::W-1:0];
		assign res = ng ? ((~qc) + {{(qrs_pkg::W-1){1'b0}}, 1'b1}) : qc;

		always_ff @(posedge clk) begin
			if (en) begin
				out_quo[l] <= res;
				out_sat[l] <= over;
			end
		end
	end

	assign out_valid = v_fin_s;
	assign out_job = job_fin_s;
endmodule
`default_nettype wire

@@ rtl/core/qrs_back.sv @@
`default_nettype none
module qrs_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [qrs_pkg::TW-1:0] tol,
	input wire logic q_empty,
	output logic pop,
	input wire qrs_pkg::entry_t pop_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] outcome,
	output logic [qrs_pkg::W-1:0] root_one,
	output logic [qrs_pkg::W-1:0] root_two,
	output logic saturated
);
	localparam int W = qrs_pkg::W;

	logic en;
	logic sq_v;
	qrs_pkg::job_t sq_job;
	logic [qrs_pkg::SW-1:0] sq_root, s;
	logic [qrs_pkg::SW+1:0] sq_rem;

	assign en = ~out_valid | out_ready;
	assign pop = en & ~q_empty;

	qrs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(pop), .in_data(pop_data),
		.out_valid(sq_v), .out_job(sq_job), .out_root(sq_root), .out_rem(sq_rem)
	);

	logic [W+2:0] bx, cx, sx, n1, n2;
	logic [W+2:0] n1a, n2a;
	logic [qrs_pkg::MW-1:0] dm;
	logic dsign, quad;

	always_comb begin
		s = sq_root + {{(qrs_pkg::SW-1){1'b0}}, (sq_rem > {2'b00, sq_root})};
		quad = sq_job.kind == qrs_pkg::KIND_QUAD;
		bx = {{3{sq_job.b[W-1]}}, sq_job.b};
		cx = {{3{sq_job.c[W-1]}}, sq_job.c};
		sx = {2'b00, s};
		if (quad) begin
			n1 = sx - bx;
			n2 = '0 - bx - sx;
			dm = {qrs_pkg::mag_w(sq_job.a), 1'b0};
			dsign = sq_job.a[W-1];
		end else begin
			n1 = '0 - cx;
			n2 = '0;
			dm = {1'b0, qrs_pkg::mag_w(sq_job.b)};
			dsign = sq_job.b[W-1];
		end
		n1a = n1[W+2] ? ('0 - n1) : n1;
		n2a = n2[W+2] ? ('0 - n2) : n2;
	end

	logic pr_v_s1;
	qrs_pkg::job_t pr_job_s1;
	logic [1:0] pr_neg_s1;
	logic [qrs_pkg::NW-1:0] pr_num_s1 [2];
	logic [qrs_pkg::MW-1:0] pr_den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pr_v_s1 <= 1'b0;
		else if (en) pr_v_s1 <= sq_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_job_s1 <= sq_job;
			pr_neg_s1 <= {n2[W+2] ^ dsign, n1[W+2] ^ dsign};
			pr_num_s1[0] <= n1a[qrs_pkg::NW-1:0];
			pr_num_s1[1] <= n2a[qrs_pkg::NW-1:0];
			pr_den_s1 <= dm;
		end
	end

	logic dv_v;
	qrs_pkg::job_t dv_job;
	logic [W-1:0] dv_quo [2];
	logic [1:0] dv_sat;

	qrs_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(pr_v_s1), .in_job(pr_job_s1), .in_neg(pr_neg_s1),
		.in_num(pr_num_s1), .in_den(pr_den_s1),
		.out_valid(dv_v), .out_job(dv_job), .out_quo(dv_quo), .out_sat(dv_sat)
	);

	logic [1:0] oc_nx;
	logic [W-1:0] r1_nx, r2_nx;
	logic sat_nx;

	always_comb begin
		oc_nx = qrs_pkg::OUT_NONE;
		r1_nx = '0;
		r2_nx = '0;
		sat_nx = 1'b0;
		unique case (dv_job.kind)
			qrs_pkg::KIND_NONE: oc_nx = qrs_pkg::OUT_NONE;
			qrs_pkg::KIND_INF: oc_nx = qrs_pkg::OUT_INF;
			qrs_pkg::KIND_LIN: begin
				oc_nx = qrs_pkg::OUT_ONE;
				sat_nx = dv_sat[0];
				if (qrs_pkg::mag_w(dv_quo[0]) < {{(W-qrs_pkg::TW){1'b0}}, tol}) r1_nx = '0;
				else r1_nx = dv_quo[0];
			end
			qrs_pkg::KIND_QUAD: begin
				sat_nx = dv_sat[0] | dv_sat[1];
				r1_nx = dv_quo[0];
				if (dv_quo[0] == dv_quo[1]) begin
					oc_nx = qrs_pkg::OUT_ONE;
				end else begin
					oc_nx = qrs_pkg::OUT_TWO;
					r2_nx = dv_quo[1];
				end
			end
			default: oc_nx = qrs_pkg::OUT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			outcome <= oc_nx;
			root_one <= r1_nx;
			root_two <= r2_nx;
			saturated <= sat_nx;
		end
	end
endmodule
`default_nettype wire
